FILE: design/hfp_pkg.sv
// shared constants, types and hex digit decode for the hex length frame parser
package hfp_pkg;

  localparam int HFP_LEN_BYTES = 4;

  localparam logic [15:0] HFP_MAX_LENGTH_RST = 16'hFFFF;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_BAD_CHAR = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG = 2'd1;
  localparam logic [1:0] ERR_EARLY_END = 2'd2;

  // parser phases
  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    logic [1:0]  error_code;
  } hfp_result_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hfp_digit_t;

  // ascii hex digit decode, either letter case
  function automatic hfp_digit_t hex_value(input logic [7:0] c);
    hfp_digit_t d;
    d.is_hex = 1'b0;
    d.value  = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.is_hex = 1'b1;
      d.value  = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d.is_hex = 1'b1;
      d.value  = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d.is_hex = 1'b1;
      d.value  = 4'(c - 8'h37);
    end
    return d;
  endfunction

endpackage

FILE: design/hfp_step.sv
// next-state and result logic for one character of the frame parser
module hfp_step
  import hfp_pkg::*;
#(
  parameter int LEN_BYTES = HFP_LEN_BYTES,
  localparam int AW   = 8 * LEN_BYTES,
  localparam int NDIG = 2 * LEN_BYTES,
  localparam int CNTW = $clog2(NDIG + 1)
) (
  input  logic [7:0]      char_in,
  input  logic [15:0]     max_length,
  input  logic [1:0]      phase,
  input  logic [AW-1:0]   accum,
  input  logic [CNTW-1:0] dig_cnt,
  input  logic [15:0]     bytes_done,
  input  logic [3:0]      high_nib,
  input  logic            nib_pend,
  output logic [1:0]      phase_nxt,
  output logic [AW-1:0]   accum_nxt,
  output logic [CNTW-1:0] dig_cnt_nxt,
  output logic [15:0]     bytes_done_nxt,
  output logic [3:0]      high_nib_nxt,
  output logic            nib_pend_nxt,
  output hfp_result_t     result
);

  hfp_digit_t  dig;
  logic        is_colon;
  logic        is_nul;
  logic [15:0] bytes_inc;

  assign dig       = hex_value(char_in);
  assign is_colon  = (char_in == CH_COLON);
  assign is_nul    = (char_in == CH_NUL);
  assign bytes_inc = bytes_done + 16'd1;

  always_comb begin
    phase_nxt      = phase;
    accum_nxt      = accum;
    dig_cnt_nxt    = dig_cnt;
    bytes_done_nxt = bytes_done;
    high_nib_nxt   = high_nib;
    nib_pend_nxt   = nib_pend;
    result         = '0;

    case (phase)
      PH_LEN: begin
        if (dig.is_hex && (dig_cnt < CNTW'(NDIG))) begin
          // high nibble of each byte comes first: slot is count with lsb flipped
          for (int n = 0; n < NDIG; n++) begin
            if (dig_cnt == CNTW'(n ^ 1)) begin
              accum_nxt[4*n +: 4] = dig.value;
            end
          end
          dig_cnt_nxt = dig_cnt + CNTW'(1);
        end else if (is_colon) begin
          if (32'(accum) > 32'(max_length)) begin
            phase_nxt         = PH_SKIP;
            result.valid      = 1'b1;
            result.kind       = KIND_ERROR;
            result.error_code = ERR_TOO_LONG;
          end else begin
            bytes_done_nxt = '0;
            nib_pend_nxt   = 1'b0;
            phase_nxt      = (accum == '0) ? PH_TAIL : PH_DATA;
          end
        end else begin
          result.valid      = 1'b1;
          result.kind       = KIND_ERROR;
          result.error_code = ERR_BAD_CHAR;
          if (is_nul) begin
            phase_nxt      = PH_LEN;
            accum_nxt      = '0;
            dig_cnt_nxt    = '0;
            bytes_done_nxt = '0;
            high_nib_nxt   = '0;
            nib_pend_nxt   = 1'b0;
          end else begin
            phase_nxt = PH_SKIP;
          end
        end
      end

      PH_DATA: begin
        if (dig.is_hex) begin
          if (!nib_pend) begin
            high_nib_nxt = dig.value;
            nib_pend_nxt = 1'b1;
          end else begin
            nib_pend_nxt      = 1'b0;
            bytes_done_nxt    = bytes_inc;
            result.valid      = 1'b1;
            result.kind       = KIND_DATA;
            result.data_byte  = {high_nib, dig.value};
            result.byte_index = bytes_done;
            if (32'(bytes_inc) >= 32'(accum)) begin
              phase_nxt = PH_TAIL;
            end
          end
        end else if (is_nul) begin
          phase_nxt         = PH_LEN;
          accum_nxt         = '0;
          dig_cnt_nxt       = '0;
          bytes_done_nxt    = '0;
          high_nib_nxt      = '0;
          nib_pend_nxt      = 1'b0;
          result.valid      = 1'b1;
          result.kind       = KIND_ERROR;
          result.error_code = ERR_EARLY_END;
        end else begin
          phase_nxt         = PH_SKIP;
          result.valid      = 1'b1;
          result.kind       = KIND_ERROR;
          result.error_code = ERR_BAD_CHAR;
        end
      end

      PH_TAIL: begin
        result.valid = 1'b1;
        if (is_nul) begin
          result.kind         = KIND_DONE;
          result.frame_length = 16'(accum);
          phase_nxt           = PH_LEN;
          accum_nxt           = '0;
          dig_cnt_nxt         = '0;
          bytes_done_nxt      = '0;
          high_nib_nxt        = '0;
          nib_pend_nxt        = 1'b0;
        end else begin
          result.kind       = KIND_ERROR;
          result.error_code = ERR_BAD_CHAR;
          phase_nxt         = PH_SKIP;
        end
      end

      default: begin
        // skipping to the next nul
        if (is_nul) begin
          phase_nxt      = PH_LEN;
          accum_nxt      = '0;
          dig_cnt_nxt    = '0;
          bytes_done_nxt = '0;
          high_nib_nxt   = '0;
          nib_pend_nxt   = 1'b0;
        end
      end
    endcase
  end

endmodule

FILE: design/hex_length_frame_parser.sv
// top level of the hex length frame parser: input stage, parse state and result register
//
// One ASCII character per transfer on the in_ channel; frames read
// LENGTH ':' DATA NUL, with LENGTH as up to LEN_BYTES hex byte pairs (low byte
// first, high nibble first) and DATA as exactly LENGTH hex byte pairs. Each
// decoded data byte is a result (kind 0), the closing NUL gives a
// frame-complete result (kind 1) carrying the length, and any fault gives one
// error result (kind 2); characters are then dropped through the next NUL,
// unless the fault was itself a NUL. A character is held in the input
// register and its result, if any, is written to the output register when
// that character is processed. One character is taken every cycle as long
// as the output side keeps up; the whole per-character update
// is one hex decode and a small compare in a single stage. in_stall rises only
// when the input register holds a character while the output register holds
// a result that is itself stalled, whether or not that character has a result
// of its own. cfg_wr_data sets max_length (reset 65535) and takes effect at
// the next colon.
module hex_length_frame_parser
  import hfp_pkg::*;
#(
  parameter int LEN_BYTES = HFP_LEN_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // character input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_byte_index,
  output logic [15:0] out_frame_length,
  output logic [1:0]  out_error_code
);

  localparam int AW   = 8 * LEN_BYTES;
  localparam int NDIG = 2 * LEN_BYTES;
  localparam int CNTW = $clog2(NDIG + 1);

  // max_length register
  logic [15:0] max_len_r;

  // input stage
  logic        in_vld_r;
  logic [7:0]  char_r;

  // parse state
  logic [1:0]      phase_r, phase_nxt;
  logic [AW-1:0]   accum_r, accum_nxt;
  logic [CNTW-1:0] dig_cnt_r, dig_cnt_nxt;
  logic [15:0]     bytes_done_r, bytes_done_nxt;
  logic [3:0]      high_nib_r, high_nib_nxt;
  logic            nib_pend_r, nib_pend_nxt;

  // output register
  logic        out_vld_r;
  hfp_result_t res_r;
  hfp_result_t step_res;

  logic out_free;   // output register can take a new result this cycle
  logic advance;    // the buffered character is processed this cycle
  logic in_xfer;

  assign out_free = !out_vld_r || !out_stall;
  assign advance  = in_vld_r && out_free;
  assign in_stall = in_vld_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= HFP_MAX_LENGTH_RST;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // input register: refilled whenever it empties or moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      char_r <= in_char_in;
    end
  end

  hfp_step #(
    .LEN_BYTES (LEN_BYTES)
  ) u_step (
    .char_in        (char_r),
    .max_length     (max_len_r),
    .phase          (phase_r),
    .accum          (accum_r),
    .dig_cnt        (dig_cnt_r),
    .bytes_done     (bytes_done_r),
    .high_nib       (high_nib_r),
    .nib_pend       (nib_pend_r),
    .phase_nxt      (phase_nxt),
    .accum_nxt      (accum_nxt),
    .dig_cnt_nxt    (dig_cnt_nxt),
    .bytes_done_nxt (bytes_done_nxt),
    .high_nib_nxt   (high_nib_nxt),
    .nib_pend_nxt   (nib_pend_nxt),
    .result         (step_res)
  );

  // parse state moves only when a character is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEN;
      accum_r      <= '0;
      dig_cnt_r    <= '0;
      bytes_done_r <= '0;
      high_nib_r   <= '0;
      nib_pend_r   <= 1'b0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      accum_r      <= accum_nxt;
      dig_cnt_r    <= dig_cnt_nxt;
      bytes_done_r <= bytes_done_nxt;
      high_nib_r   <= high_nib_nxt;
      nib_pend_r   <= nib_pend_nxt;
    end
  end

  // result register: characters with no result leave it empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= advance && step_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      res_r <= step_res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = res_r.kind;
  assign out_data_byte    = res_r.data_byte;
  assign out_byte_index   = res_r.byte_index;
  assign out_frame_length = res_r.frame_length;
  assign out_error_code   = res_r.error_code;

endmodule

FILE: bench/tb_top.sv
// self-checking testbench for the hex length frame parser
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hfp_pkg::*;

  localparam int LEN_DIGITS = 2 * HFP_LEN_BYTES;

  // one expected result, same fields as the out_ channel
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    logic [1:0]  error_code;
  } parse_res_t;

  // ways a generated frame can be broken
  typedef enum int {
    FL_NONE,
    FL_LEN_CHAR,    // junk inside the length field
    FL_FULL_FIELD,  // a ninth length digit instead of the colon
    FL_DATA_CHAR,   // junk inside the data
    FL_EARLY_NUL,   // frame cut short by a NUL
    FL_EXTRA        // stray character between the data and the NUL
  } frame_flaw_e;

  // clock, reset and DUT ports; every input starts at a known value
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [15:0] out_byte_index;
  logic [15:0] out_frame_length;
  logic [1:0]  out_error_code;

  // characters waiting to go out, and decoded results waiting to come back
  logic [7:0]  char_q[$];
  parse_res_t  expected_q[$];

  // parser state as the bench sees it
  logic [1:0]  ph;
  logic [31:0] len_acc;
  logic [3:0]  len_digits;
  logic [15:0] bytes_out;
  logic [3:0]  hi_nib;
  bit          nib_held;
  logic [15:0] max_len;

  bit quiet = 1'b0;        // when set neither side idles
  int fault_count = 0;
  int result_count = 0;
  int chars_pushed = 0;

  hex_length_frame_parser DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_byte_index  (out_byte_index),
    .out_frame_length(out_frame_length),
    .out_error_code  (out_error_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // frame decode
  // ---------------------------------------------------------------------------

  // ascii hex digit to nibble, either letter case
  function automatic void hex_nibble(input logic [7:0] c, output bit ok,
                                     output logic [3:0] val);
    ok  = 1'b1;
    val = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) val = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) val = c[3:0] + 4'd9;
    else ok = 1'b0;
  endfunction

  function automatic void restart_frame();
    ph         = PH_LEN;
    len_acc    = '0;
    len_digits = '0;
    bytes_out  = '0;
    hi_nib     = '0;
    nib_held   = 1'b0;
  endfunction

  // error result; a fault that also ends the frame starts a new one at once,
  // otherwise the parser drops characters through the next NUL
  function automatic parse_res_t raise_fault(input logic [1:0] code, input bit ended);
    parse_res_t r;
    if (ended) restart_frame();
    else ph = PH_SKIP;
    r = '0;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return r;
  endfunction

  // advance the parser by one character; has_res tells whether it yields a result
  function automatic void parse_char(input logic [7:0] c, output bit has_res,
                                     output parse_res_t res);
    bit         ok;
    logic [3:0] nib;
    logic [5:0] sh;
    hex_nibble(c, ok, nib);
    has_res = 1'b0;
    res = '0;
    case (ph)
      PH_LEN: begin
        if (ok && len_digits < LEN_DIGITS) begin
          // low byte first, high nibble first within a byte
          sh = 6'(8 * (len_digits >> 1)) + (len_digits[0] ? 6'd0 : 6'd4);
          len_acc = len_acc | (32'(nib) << sh);
          len_digits = len_digits + 4'd1;
        end else if (c == CH_COLON) begin
          if (len_acc > {16'h0, max_len}) begin
            res = raise_fault(ERR_TOO_LONG, 1'b0);
            has_res = 1'b1;
          end else begin
            bytes_out = '0;
            nib_held = 1'b0;
            ph = (len_acc == 0) ? PH_TAIL : PH_DATA;
          end
        end else begin
          // a NUL here is still a bad character, but it closes the frame
          res = raise_fault(ERR_BAD_CHAR, c == CH_NUL);
          has_res = 1'b1;
        end
      end
      PH_DATA: begin
        if (ok && !nib_held) begin
          hi_nib = nib;
          nib_held = 1'b1;
        end else if (ok) begin
          res.kind = KIND_DATA;
          res.data_byte = {hi_nib, nib};
          res.byte_index = bytes_out;
          has_res = 1'b1;
          nib_held = 1'b0;
          bytes_out = bytes_out + 16'd1;
          if ({16'h0, bytes_out} >= len_acc) ph = PH_TAIL;
        end else begin
          res = raise_fault(c == CH_NUL ? ERR_EARLY_END : ERR_BAD_CHAR, c == CH_NUL);
          has_res = 1'b1;
        end
      end
      PH_TAIL: begin
        if (c == CH_NUL) begin
          res.kind = KIND_DONE;
          res.frame_length = len_acc[15:0];
          restart_frame();
        end else begin
          res = raise_fault(ERR_BAD_CHAR, 1'b0);
        end
        has_res = 1'b1;
      end
      default: begin
        if (c == CH_NUL) restart_frame();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic note_fault(input string msg);
    fault_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      note_fault($sformatf("result %0d %s got %0d want %0d", result_count, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // driver: one character per transfer from char_q, idling at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    bit         has_res;
    parse_res_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // a transfer at this edge moves the bench's parser on by one character
      if (in_valid && !in_stall) begin
        parse_char(in_char_in, has_res, res);
        if (has_res) expected_q.push_back(res);
      end
      // a held character stays put until it transfers
      if (!in_valid || !in_stall) begin
        if (char_q.size() != 0 && (quiet || $urandom_range(99) >= 31)) begin
          in_valid   <= 1'b1;
          in_char_in <= char_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compare each result transfer with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_proc
    parse_res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          note_fault($sformatf("unexpected result kind %0d", out_kind));
        end else begin
          want = expected_q.pop_front();
          check_field("kind", out_kind, want.kind);
          check_field("data_byte", out_data_byte, want.data_byte);
          check_field("byte_index", out_byte_index, want.byte_index);
          check_field("frame_length", out_frame_length, want.frame_length);
          check_field("error_code", out_error_code, want.error_code);
        end
        result_count++;
      end
      out_stall <= !quiet && ($urandom_range(99) < 31);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_char(input logic [7:0] c);
    char_q.push_back(c);
    chars_pushed++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // hex digit for a nibble, letter case picked at random
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'h30 + 8'(v);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // any character that is not a hex digit
  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    bit         ok;
    logic [3:0] v;
    do begin
      c = 8'($urandom_range(255));
      hex_nibble(c, ok, v);
    end while (ok);
    return c;
  endfunction

  // queue one frame of the given length, broken in the given way
  task automatic push_frame(input logic [31:0] len, input frame_flaw_e flaw);
    int         nb;
    int         cut;
    logic [7:0] b;
    nb = 0;
    while (nb < HFP_LEN_BYTES && (len >> (8 * nb)) != 0) nb++;
    if (flaw == FL_FULL_FIELD) nb = HFP_LEN_BYTES;
    else if ($urandom_range(3) == 0) nb = $urandom_range(nb, HFP_LEN_BYTES);
    for (int i = 0; i < nb; i++) begin
      b = len[8*i +: 8];
      push_char(hex_char(b[7:4]));
      // a lone high digit is allowed on the last byte when its low nibble is 0
      if (!(flaw != FL_FULL_FIELD && i == nb - 1 && b[3:0] == 4'h0 && $urandom_range(3) == 0))
        push_char(hex_char(b[3:0]));
    end
    if (flaw == FL_LEN_CHAR || flaw == FL_FULL_FIELD) begin
      push_char(flaw == FL_LEN_CHAR ? junk_char() : hex_char(4'($urandom_range(15))));
      push_char(CH_NUL);
      return;
    end
    push_char(CH_COLON);
    if (len > {16'h0, max_len}) begin
      // refused at the colon; whatever follows is skipped
      repeat ($urandom_range(3)) push_char(hex_char(4'($urandom_range(15))));
      push_char(CH_NUL);
      return;
    end
    if (len == 0 && (flaw == FL_DATA_CHAR || flaw == FL_EARLY_NUL)) flaw = FL_EXTRA;
    cut = (len == 0) ? 0 : $urandom_range(0, 2 * len - 1);
    for (int j = 0; j < 2 * len; j++) begin
      if (flaw == FL_EARLY_NUL && j == cut) begin
        push_char(CH_NUL);
        return;
      end
      if (flaw == FL_DATA_CHAR && j == cut) push_char(junk_char());
      else push_char(hex_char(4'($urandom_range(15))));
    end
    if (flaw == FL_EXTRA) push_char(8'($urandom_range(1, 255)));
    push_char(CH_NUL);
  endtask

  // mostly well-formed frames with random content, the rest broken frames and noise
  task automatic random_frames(input int count);
    int          stop;
    int          sel;
    int          pick;
    logic [31:0] len;
    stop = chars_pushed + count;
    while (chars_pushed < stop) begin
      sel  = $urandom_range(99);
      pick = $urandom_range(99);
      if (pick < 80)      len = $urandom_range(0, 12);
      else if (pick < 92) len = $urandom_range(13, 48);
      else if (pick < 96) len = {16'h0, max_len} + 32'd1;
      else                len = $urandom | 32'h0001_0000;
      if (sel < 70) begin
        push_frame(len, FL_NONE);
      end else if (sel < 90) begin
        push_frame(len, frame_flaw_e'($urandom_range(FL_LEN_CHAR, FL_EXTRA)));
      end else begin
        repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(255)));
        if ($urandom_range(1)) push_char(CH_NUL);
      end
    end
  endtask

  // sender holds off until every character is out and every result is back,
  // then lets anything still in the pipeline drain
  task automatic wait_idle();
    do @(posedge clk);
    while (char_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    max_len = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stim_proc
    max_len = HFP_MAX_LENGTH_RST;
    restart_frame();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames at the reset setting
    push_text(":");          push_char(CH_NUL);  // empty length field
    push_text("0:");         push_char(CH_NUL);  // lone digit, length zero
    push_text("02:00fF");    push_char(CH_NUL);  // data extremes, mixed case
    push_text("01:a");       push_char(CH_NUL);  // early NUL in data
    push_text("01:Bc?");     push_char(CH_NUL);  // extra character after data
    push_char(CH_NUL);                           // NUL as a bad length character
    push_text("z");          push_char(CH_NUL);  // bad length character, then skip
    push_text("FFFFFFFF:");  push_char(CH_NUL);  // full field, length over max
    random_frames(250);
    wait_idle();

    write_max(16'd8);
    random_frames(150);
    wait_idle();

    write_max(16'd0);
    random_frames(100);
    wait_idle();

    // long stretch with neither side idling
    write_max(16'hFFFF);
    quiet = 1'b1;
    random_frames(150);
    wait_idle();
    quiet = 1'b0;

    write_max(16'($urandom_range(1, 40)));
    random_frames(100);
    wait_idle();

    repeat (8) @(posedge clk);
    if (expected_q.size() != 0)
      note_fault($sformatf("%0d results never arrived", expected_q.size()));
    if (fault_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin : watchdog_proc
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
